/* sv/fpmc_pkg.sv */
// Shared types and constants of the factor engine.
// Holds op codes, controller command and status structs, and the weight table.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fpmc_pkg;

  localparam logic [1:0] OpScore = 2'd0;
  localparam logic [1:0] OpTrain = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;
  localparam logic [1:0] OpRead  = 2'd3;

  localparam logic [1:0] TabUser = 2'd0;
  localparam logic [1:0] TabItem = 2'd1;
  localparam logic [1:0] TabPrev = 2'd2;
  localparam logic [1:0] TabNext = 2'd3;

  localparam logic CfgLearnRate = 1'b0;
  localparam logic CfgRegular   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input word
    logic clr_acc;    // clear the dot product accumulator
    logic rd_user;    // issue reads of the user/item element
    logic rd_trans;   // issue reads of the transition element
    logic acc_en;     // accumulate the product of the read data
    logic fin_score;  // round and saturate the sum
    logic wgt_en;     // compute the weight
    logic upd_user;   // write updated user/item element
    logic upd_trans;  // write updated transition element
    logic word_acc;   // perform single word write or read
    logic word_cap;   // capture single word read data
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
  } sts_t;

  function automatic logic [16:0] wtab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0: v = 17'd32768;  5'd1: v = 17'd24743;  5'd2: v = 17'd17626;
      5'd3: v = 17'd11955;  5'd4: v = 17'd7812;   5'd5: v = 17'd4971;
      5'd6: v = 17'd3108;   5'd7: v = 17'd1921;   5'd8: v = 17'd1179;
      5'd9: v = 17'd720;    5'd10: v = 17'd439;   5'd11: v = 17'd267;
      5'd12: v = 17'd162;   5'd13: v = 17'd98;    5'd14: v = 17'd60;
      5'd15: v = 17'd36;    default: v = 17'd22;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/fpmc_ctrl.sv */
// Controller state machine of the factor engine.
// Sequences reads, accumulation, weight and updates; uses fpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpmc_ctrl #(
  parameter int unsigned K  = 16,
  parameter int unsigned KK = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_fire_i,
  input  fpmc_pkg::sts_t      sts_i,
  input  wire                 out_free_i,
  output logic                busy_o,
  output logic                done_o,
  output fpmc_pkg::ctl_t      ctl_o,
  output logic [6:0]          elem_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRdU   = 4'd1;
  localparam logic [3:0] SRdT   = 4'd2;
  localparam logic [3:0] SDrain = 4'd3;
  localparam logic [3:0] SFin   = 4'd4;
  localparam logic [3:0] SWgt   = 4'd5;
  localparam logic [3:0] SUpU   = 4'd6;
  localparam logic [3:0] SUpT   = 4'd7;
  localparam logic [3:0] SWord  = 4'd8;
  localparam logic [3:0] SWCap  = 4'd9;
  localparam logic [3:0] SDone  = 4'd10;
  localparam logic [6:0] KM1  = 7'(K - 1);
  localparam logic [6:0] KKM1 = 7'(KK - 1);

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [1:0] drain_q, drain_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drain_d = drain_q;
    ctl_o   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_fire_i) begin
          ctl_o.load    = 1'b1;
          ctl_o.clr_acc = 1'b1;
          cnt_d         = '0;
          state_d       = SRdU;
        end
      end
      SRdU: begin
        if (sts_i.op == fpmc_pkg::OpWrite || sts_i.op == fpmc_pkg::OpRead) begin
          state_d = SWord;
        end else begin
          ctl_o.rd_user = 1'b1;
          if (cnt_q == KM1) begin
            cnt_d = '0; state_d = SRdT;
          end else cnt_d = cnt_q + 7'd1;
        end
      end
      SRdT: begin
        ctl_o.rd_trans = 1'b1;
        if (cnt_q == KKM1) begin
          drain_d = '0; state_d = SDrain;
        end else cnt_d = cnt_q + 7'd1;
      end
      SDrain: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) state_d = SFin;
      end
      SFin: begin
        ctl_o.fin_score = 1'b1;
        state_d = (sts_i.op == fpmc_pkg::OpTrain) ? SWgt : SDone;
      end
      SWgt: begin
        ctl_o.wgt_en = 1'b1;
        cnt_d = '0;
        state_d = SUpU;
      end
      SUpU: begin
        ctl_o.upd_user = 1'b1;
        if (cnt_q == KM1) begin
          cnt_d = '0; state_d = SUpT;
        end else cnt_d = cnt_q + 7'd1;
      end
      SUpT: begin
        ctl_o.upd_trans = 1'b1;
        if (cnt_q == KKM1) begin
          drain_d = '0; state_d = SDone;
        end else cnt_d = cnt_q + 7'd1;
      end
      SWord: begin
        ctl_o.word_acc = 1'b1;
        state_d = SWCap;
      end
      SWCap: begin
        ctl_o.word_cap = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        // Update writes trail their reads through the s1, s2 and s3 datapath registers, so wait.
        if (drain_q != 2'd3) drain_d = drain_q + 2'd1;
        else if (out_free_i) begin
          done_o  = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);
  assign elem_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
    end
  end

endmodule
`default_nettype wire

/* sv/fpmc_dpath.sv */
// Datapath of the factor engine: four factor memories, multiply-accumulate,
// weight lookup and the element update pipeline. Uses fpmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpmc_dpath #(
  parameter int unsigned K  = 16,
  parameter int unsigned KK = 16,
  parameter int unsigned NU = 1024,
  parameter int unsigned NI = 4096
) (
  input  wire                 clk_i,
  input  wire  fpmc_pkg::ctl_t ctl_i,
  input  wire  [6:0]          elem_i,
  input  wire  [69:0]         in_word_i,
  input  wire  [15:0]         learn_rate_i,
  input  wire  [15:0]         regular_i,
  output fpmc_pkg::sts_t      sts_o,
  output logic signed [15:0]  score_o,
  output logic signed [15:0]  read_o
);

  localparam int unsigned UAW = $clog2(NU * K);
  localparam int unsigned IAW = $clog2(NI * K);
  localparam int unsigned TAW = $clog2(NI * KK);
  localparam int unsigned UW  = (NU > 1) ? $clog2(NU) : 1;
  localparam int unsigned IW  = (NI > 1) ? $clog2(NI) : 1;

  logic signed [15:0] umem [NU*K];
  logic signed [15:0] imem [NI*K];
  logic signed [15:0] pmem [NI*KK];
  logic signed [15:0] nmem [NI*KK];

  // Captured input fields.
  logic [1:0]  op_q, sel_q;
  logic [15:0] u_q, p_q, i_q, n_q;
  logic [3:0]  el_q;
  logic signed [15:0] wv_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q <= in_word_i[1:0];
      u_q  <= 16'(in_word_i[11:2] % NU);
      p_q  <= 16'(in_word_i[23:12] % NI);
      i_q  <= 16'(in_word_i[35:24] % NI);
      n_q  <= 16'(in_word_i[47:36] % NI);
      sel_q <= in_word_i[49:48];
      el_q <= in_word_i[53:50];
      wv_q <= in_word_i[69:54];
    end
  end
  assign sts_o.op = op_q;

  // Address generation; an update pass re-reads the rows and writes them back after the s1, s2 and s3 registers.
  logic rd_u, rd_t;
  assign rd_u = ctl_i.rd_user  | ctl_i.upd_user;
  assign rd_t = ctl_i.rd_trans | ctl_i.upd_trans;

  logic [UAW-1:0] ua;
  logic [IAW-1:0] ia, na;
  logic [TAW-1:0] pa, ta, ma;
  assign ua = UAW'(u_q[UW-1:0] * K + elem_i);
  assign ia = IAW'(i_q[IW-1:0] * K + elem_i);
  assign na = IAW'(n_q[IW-1:0] * K + elem_i);
  assign pa = TAW'(p_q[IW-1:0] * KK + elem_i);
  assign ta = TAW'(i_q[IW-1:0] * KK + elem_i);
  assign ma = TAW'(n_q[IW-1:0] * KK + elem_i);

  // Single word addressing (transition tables are keyed by item).
  logic word_ok;
  logic [UAW-1:0] wua;
  logic [IAW-1:0] wia;
  logic [TAW-1:0] wta;
  assign word_ok = (sel_q == fpmc_pkg::TabUser || sel_q == fpmc_pkg::TabItem) ?
                   (32'(el_q) < K) : (32'(el_q) < KK);
  assign wua = UAW'(u_q[UW-1:0] * K + el_q);
  assign wia = IAW'(i_q[IW-1:0] * K + el_q);
  assign wta = TAW'(i_q[IW-1:0] * KK + el_q);

  // Registered read data: a = user/prev, b = pos, c = neg.
  logic signed [15:0] a_q, b_q, c_q, wr_q;
  logic               s1_u_q, s1_t_q, s1_upd_q;
  logic [UAW-1:0]     s1_ua_q;
  logic [IAW-1:0]     s1_ia_q, s1_na_q;
  logic [TAW-1:0]     s1_pa_q, s1_ta_q, s1_ma_q;

  always_ff @(posedge clk_i) begin
    if (rd_u) begin
      a_q <= umem[ua]; b_q <= imem[ia]; c_q <= imem[na];
    end else if (rd_t) begin
      a_q <= pmem[pa]; b_q <= nmem[ta]; c_q <= nmem[ma];
    end
    if (ctl_i.word_acc) begin
      unique case (sel_q)
        fpmc_pkg::TabUser: wr_q <= umem[wua];
        fpmc_pkg::TabItem: wr_q <= imem[wia];
        fpmc_pkg::TabPrev: wr_q <= pmem[wta];
        default:           wr_q <= nmem[wta];
      endcase
    end
    s1_u_q <= rd_u; s1_t_q <= rd_t;
    s1_upd_q <= ctl_i.upd_user | ctl_i.upd_trans;
    s1_ua_q <= ua; s1_ia_q <= ia; s1_na_q <= na;
    s1_pa_q <= pa; s1_ta_q <= ta; s1_ma_q <= ma;
  end

  // Stage 2: products (score pass) or gradient products (update pass).
  logic signed [16:0] diff;
  logic signed [33:0] prod_q;
  logic signed [16:0] w_q;
  logic signed [34:0] ta_q, tb_q, tc_q;
  logic signed [15:0] a2_q, b2_q, c2_q;
  logic               s2_acc_q, s2_u_q, s2_t_q, s2_upd_q;
  logic [UAW-1:0]     s2_ua_q;
  logic [IAW-1:0]     s2_ia_q, s2_na_q;
  logic [TAW-1:0]     s2_pa_q, s2_ta_q, s2_ma_q;
  logic signed [16:0] lam;
  assign lam  = $signed({1'b0, regular_i});
  assign diff = 17'(b_q) - 17'(c_q);

  always_ff @(posedge clk_i) begin
    prod_q <= 34'(a_q) * 34'(op_q == fpmc_pkg::OpTrain ? diff : 17'(b_q));
    ta_q <= 35'(w_q) * 35'(diff) - 35'(lam) * 35'(a_q);
    tb_q <= 35'(w_q) * 35'(a_q)  - 35'(lam) * 35'(b_q);
    tc_q <= -(35'(w_q) * 35'(a_q)) - 35'(lam) * 35'(c_q);
    a2_q <= a_q; b2_q <= b_q; c2_q <= c_q;
    s2_acc_q <= (s1_u_q | s1_t_q) & ~s1_upd_q;
    s2_u_q <= s1_u_q; s2_t_q <= s1_t_q; s2_upd_q <= s1_upd_q;
    s2_ua_q <= s1_ua_q; s2_ia_q <= s1_ia_q; s2_na_q <= s1_na_q;
    s2_pa_q <= s1_pa_q; s2_ta_q <= s1_ta_q; s2_ma_q <= s1_ma_q;
  end

  // Accumulator and score.
  logic signed [40:0] acc_q;
  logic signed [40:0] rnd;
  logic signed [15:0] score_q;
  assign rnd = (acc_q + 41'sd2048) >>> 12;
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_acc) acc_q <= '0;
    else if (s2_acc_q) acc_q <= acc_q + 41'(prod_q);
    if (ctl_i.clr_acc) score_q <= '0;
    else if (ctl_i.fin_score) begin
      if (rnd > 41'sd32767) score_q <= 16'sh7fff;
      else if (rnd < -41'sd32768) score_q <= -16'sh8000;
      else score_q <= rnd[15:0];
    end
  end
  assign score_o = score_q;

  // Weight from the table with linear interpolation.
  logic [15:0] ax;
  logic [16:0] tv0, tv1, tv;
  logic [27:0] ip;
  assign ax  = score_q[15] ? 16'(-score_q) : score_q;
  assign tv0 = fpmc_pkg::wtab(ax[15:11]);
  assign tv1 = fpmc_pkg::wtab(ax[15:11] + 5'd1);
  assign ip  = 28'(tv0 - tv1) * 28'(ax[10:0]) + 28'd1024;
  assign tv  = (ax[15:11] >= 5'd16) ? fpmc_pkg::wtab(5'd16) : tv0 - 17'(ip[27:11]);
  always_ff @(posedge clk_i) begin
    if (ctl_i.wgt_en) w_q <= score_q[15] ? $signed(17'd65536 - tv) : $signed(tv);
  end

  // Stage 3: delta = lr*t rounded by 2^-32; then saturating add and write.
  logic signed [51:0] da, db, dc;
  logic signed [51:0] lr;
  assign lr = $signed({36'd0, learn_rate_i});
  assign da = lr * 52'(ta_q) + 52'sh80000000;
  assign db = lr * 52'(tb_q) + 52'sh80000000;
  assign dc = lr * 52'(tc_q) + 52'sh80000000;
  logic signed [19:0] da_q, db_q, dc_q;
  logic signed [15:0] a3_q, b3_q, c3_q;
  logic s3_u_q, s3_t_q, s3_upd_q;
  logic [UAW-1:0] s3_ua_q;
  logic [IAW-1:0] s3_ia_q, s3_na_q;
  logic [TAW-1:0] s3_pa_q, s3_ta_q, s3_ma_q;

  always_ff @(posedge clk_i) begin
    da_q <= 20'(da >>> 32); db_q <= 20'(db >>> 32); dc_q <= 20'(dc >>> 32);
    a3_q <= a2_q; b3_q <= b2_q; c3_q <= c2_q;
    s3_u_q <= s2_u_q; s3_t_q <= s2_t_q; s3_upd_q <= s2_upd_q;
    s3_ua_q <= s2_ua_q; s3_ia_q <= s2_ia_q; s3_na_q <= s2_na_q;
    s3_pa_q <= s2_pa_q; s3_ta_q <= s2_ta_q; s3_ma_q <= s2_ma_q;
  end

  function automatic logic signed [15:0] sat(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  logic signed [15:0] na_v, nb_v, nc_v;
  assign na_v = sat(21'(a3_q) + 21'(da_q));
  assign nb_v = sat(21'(b3_q) + 21'(db_q));
  assign nc_v = sat(21'(c3_q) + 21'(dc_q));

  // Port A writes: updates, or the single word write. Positive then negative row.
  always_ff @(posedge clk_i) begin
    if (s3_upd_q && s3_u_q) begin
      umem[s3_ua_q] <= na_v;
      imem[s3_ia_q] <= (s3_ia_q == s3_na_q) ? nc_v : nb_v;
      imem[s3_na_q] <= nc_v;
    end else if (s3_upd_q && s3_t_q) begin
      pmem[s3_pa_q] <= na_v;
      nmem[s3_ta_q] <= (s3_ta_q == s3_ma_q) ? nc_v : nb_v;
      nmem[s3_ma_q] <= nc_v;
    end else if (ctl_i.word_acc && op_q == fpmc_pkg::OpWrite && word_ok) begin
      unique case (sel_q)
        fpmc_pkg::TabUser: umem[wua] <= wv_q;
        fpmc_pkg::TabItem: imem[wia] <= wv_q;
        fpmc_pkg::TabPrev: pmem[wta] <= wv_q;
        default:           nmem[wta] <= wv_q;
      endcase
    end
  end

  logic signed [15:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_acc) rd_q <= '0;
    else if (ctl_i.word_cap && op_q == fpmc_pkg::OpRead && word_ok) rd_q <= wr_q;
  end
  assign read_o = rd_q;

endmodule
`default_nettype wire

/* sv/fpmc_bpr_sgd_engine.sv */
// Factor engine: scores a (user, previous item, item) triple and runs one BPR
// gradient step over Q4.12 factor tables held in on-chip memory. One word at
// a time: a score reads the factor elements one after another, and an update
// reads them again and writes them back one after another. The result register
// frees the input once taken. Tables have no defined reset and must be
// loaded by word writes before use.
`timescale 1ns / 1ps
`default_nettype none
module fpmc_bpr_sgd_engine #(
  parameter int unsigned USER_ITEM_FACTORS  = 16,
  parameter int unsigned TRANSITION_FACTORS = 16,
  parameter int unsigned NUM_USERS          = 1024,
  parameter int unsigned NUM_ITEMS          = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], user_index[11:2], prev_item_index[23:12], item_index[35:24],
  // neg_item_index[47:36], table_select[49:48], element_index[53:50],
  // word_value[69:54], zero fill
  input  wire  [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // score[15:0], read_value[31:16]
  output logic [31:0] m_axis_tdata,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  logic [15:0] lr_q, lam_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= 16'd655;
      lam_q <= 16'd66;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fpmc_pkg::CfgLearnRate: lr_q  <= cfg_data_i;
        default:                lam_q <= cfg_data_i;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  logic busy, done, in_fire;
  fpmc_pkg::ctl_t ctl;
  fpmc_pkg::sts_t sts;
  logic [6:0] elem;
  logic signed [15:0] score, rdv;

  assign s_axis_tready = ~busy;
  assign in_fire = s_axis_tvalid & s_axis_tready;

  fpmc_ctrl #(.K(USER_ITEM_FACTORS), .KK(TRANSITION_FACTORS)) u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .sts_i(sts),
    .out_free_i(~m_axis_tvalid | m_axis_tready),
    .busy_o(busy), .done_o(done), .ctl_o(ctl), .elem_o(elem)
  );

  fpmc_dpath #(.K(USER_ITEM_FACTORS), .KK(TRANSITION_FACTORS),
               .NU(NUM_USERS), .NI(NUM_ITEMS)) u_dpath (
    .clk_i, .ctl_i(ctl), .elem_i(elem), .in_word_i(s_axis_tdata[69:0]),
    .learn_rate_i(lr_q), .regular_i(lam_q), .sts_o(sts),
    .score_o(score), .read_o(rdv)
  );

  logic        ov_q;
  logic [31:0] od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) od_q <= {rdv, score};
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench of the FPMC factor engine: a predictor with its own copy
// of the four factor tables checks every result word. Depends on fpmc_pkg and on
// fpmc_bpr_sgd_engine.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic signed [15:0] rd;
    logic signed [15:0] score;
  } result_t;

  typedef struct {
    logic [1:0]         op;
    logic [9:0]         u;
    logic [11:0]        p;
    logic [11:0]        i;
    logic [11:0]        n;
    logic [1:0]         sel;
    logic [3:0]         el;
    logic signed [15:0] wv;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  localparam int K  = 16;
  localparam int KK = 16;
  localparam int IdleLimit = 4000;
  localparam int LongHold = 400;
  localparam int wtab_c [17] = '{32768, 24743, 17626, 11955, 7812, 4971, 3108, 1921,
                                 1179, 720, 439, 267, 162, 98, 60, 36, 22};
  localparam logic [9:0]  users_c [4] = '{10'd0, 10'd1023, 10'h155, 10'h2AA};
  localparam logic [11:0] items_c [6] = '{12'd0, 12'd4095, 12'h555, 12'hAAA, 12'd7, 12'd100};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  wire         s_tready, m_tvalid, cfg_ready;
  wire  [31:0] m_tdata;

  fpmc_bpr_sgd_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state.
  logic [15:0]        lr_q, lam_q;
  logic signed [15:0] ufac [K*1024];
  logic signed [15:0] ifac [K*4096];
  logic signed [15:0] pfac [KK*4096];
  logic signed [15:0] nfac [KK*4096];

  result_t     expected_q [$];
  stim_row_t   dir_tab [$];
  int          errors = 0;
  int          words_in = 0;
  int          idle_cycles = 0;
  int          burst_left = 1;
  bit          held = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint bpr_weight(input logic signed [15:0] x);
    int a, idx, frac, v;
    a = (x < 0) ? -int'(x) : int'(x);
    idx = a >> 11;
    frac = a & 2047;
    if (idx >= 16) v = wtab_c[16];
    else v = wtab_c[idx] - (((wtab_c[idx] - wtab_c[idx+1]) * frac + 1024) >> 11);
    return (x < 0) ? 65536 - v : v;
  endfunction

  function automatic logic signed [15:0] sgd_step(input logic signed [15:0] old, input longint t);
    longint d;
    d = (longint'(lr_q) * t + (64'sd1 <<< 31)) >>> 32;
    return sat16(longint'(old) + d);
  endfunction

  // Works out the result word of one command and applies its effect to the tables.
  function automatic result_t engine_predict(input logic [71:0] w);
    logic [1:0] op, sel;
    int u, p, it, ng, el, f;
    longint acc, wt, lam;
    logic signed [15:0] a, b, c, na, nb, nc;
    result_t r;
    op = w[1:0]; u = w[11:2]; p = w[23:12]; it = w[35:24]; ng = w[47:36];
    sel = w[49:48]; el = w[53:50];
    r = '0;
    acc = 0;
    lam = lam_q;
    if (op == fpmc_pkg::OpScore) begin
      for (f = 0; f < K; f++) acc += longint'(ufac[u*K+f]) * ifac[it*K+f];
      for (f = 0; f < KK; f++) acc += longint'(pfac[p*KK+f]) * nfac[it*KK+f];
      r.score = sat16((acc + 2048) >>> 12);
    end else if (op == fpmc_pkg::OpTrain) begin
      for (f = 0; f < K; f++)
        acc += longint'(ufac[u*K+f]) * (longint'(ifac[it*K+f]) - ifac[ng*K+f]);
      for (f = 0; f < KK; f++)
        acc += longint'(pfac[p*KK+f]) * (longint'(nfac[it*KK+f]) - nfac[ng*KK+f]);
      r.score = sat16((acc + 2048) >>> 12);
      wt = bpr_weight(r.score);
      for (f = 0; f < K; f++) begin
        a = ufac[u*K+f]; b = ifac[it*K+f]; c = ifac[ng*K+f];
        na = sgd_step(a, wt * (longint'(b) - c) - lam * a);
        nb = sgd_step(b, wt * a - lam * b);
        nc = sgd_step(c, -wt * a - lam * c);
        ufac[u*K+f] = na; ifac[it*K+f] = nb; ifac[ng*K+f] = nc;
      end
      for (f = 0; f < KK; f++) begin
        a = pfac[p*KK+f]; b = nfac[it*KK+f]; c = nfac[ng*KK+f];
        na = sgd_step(a, wt * (longint'(b) - c) - lam * a);
        nb = sgd_step(b, wt * a - lam * b);
        nc = sgd_step(c, -wt * a - lam * c);
        pfac[p*KK+f] = na; nfac[it*KK+f] = nb; nfac[ng*KK+f] = nc;
      end
    end else begin
      // Both transition tables are addressed by the item index for word access.
      if (op == fpmc_pkg::OpWrite) begin
        case (sel)
          fpmc_pkg::TabUser: ufac[u*K+el] = w[69:54];
          fpmc_pkg::TabItem: ifac[it*K+el] = w[69:54];
          fpmc_pkg::TabPrev: pfac[it*KK+el] = w[69:54];
          default:           nfac[it*KK+el] = w[69:54];
        endcase
      end else begin
        case (sel)
          fpmc_pkg::TabUser: r.rd = ufac[u*K+el];
          fpmc_pkg::TabItem: r.rd = ifac[it*K+el];
          fpmc_pkg::TabPrev: r.rd = pfac[it*KK+el];
          default:           r.rd = nfac[it*KK+el];
        endcase
      end
    end
    return r;
  endfunction

  // Offers one command word, holds it until taken and then opens a gap now and then.
  task automatic send_cmd(input stim_row_t s);
    logic [71:0] w;
    result_t pred;
    w = {2'b00, s.wv, s.el, s.sel, s.n, s.i, s.p, s.u, s.op};
    s_tdata <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = engine_predict(w);
    expected_q = {expected_q, (s.typed ? s.res : pred)};
    words_in++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fpmc_pkg::CfgLearnRate) lr_q = val;
    else lam_q = val;
    @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [9:0] u, input logic [11:0] p,
                         input logic [11:0] i, input logic [11:0] n, input logic [1:0] sel,
                         input logic [3:0] el, input logic signed [15:0] wv,
                         input bit typed, input logic signed [15:0] sc,
                         input logic signed [15:0] rd);
    stim_row_t s;
    s.op = op; s.u = u; s.p = p; s.i = i; s.n = n; s.sel = sel; s.el = el; s.wv = wv;
    s.typed = typed; s.res.score = sc; s.res.rd = rd;
    dir_tab = {dir_tab, s};
  endtask

  function automatic stim_row_t random_cmd;
    stim_row_t s;
    int pick;
    s.u = users_c[$urandom_range(0, 3)];
    s.p = items_c[$urandom_range(0, 5)];
    s.i = items_c[$urandom_range(0, 5)];
    s.n = ($urandom_range(0, 7) == 0) ? s.i : items_c[$urandom_range(0, 5)];
    s.sel = 2'($urandom_range(0, 3));
    s.el = 4'($urandom_range(0, 15));
    s.wv = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8191) - 4096) : 16'($urandom);
    s.typed = 1'b0;
    s.res = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) s.op = fpmc_pkg::OpScore;
    else if (pick < 70) s.op = fpmc_pkg::OpTrain;
    else if (pick < 85) begin
      s.op = fpmc_pkg::OpWrite;
      // Writes may go anywhere; only the working rows are ever read.
      if ($urandom_range(0, 1) == 0) begin
        s.u = 10'($urandom);
        s.i = 12'($urandom);
      end
    end else s.op = fpmc_pkg::OpRead;
    return s;
  endfunction

  // Stimulus.
  initial begin
    stim_row_t s;
    logic [15:0] lr_set [5];
    logic [15:0] lam_set [5];
    lr_q = 16'd655;
    lam_q = 16'd66;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every row that a score, an update or a read will touch.
    s.typed = 1'b0; s.res = '0; s.op = fpmc_pkg::OpWrite; s.p = '0; s.n = '0;
    foreach (users_c[k]) for (int e = 0; e < K; e++) begin
      s.u = users_c[k]; s.i = '0; s.sel = fpmc_pkg::TabUser; s.el = 4'(e);
      s.wv = 16'($urandom_range(0, 8191) - 4096);
      send_cmd(s);
    end
    foreach (items_c[k]) for (int t = 1; t < 4; t++) for (int e = 0; e < K; e++) begin
      s.u = '0; s.i = items_c[k]; s.sel = 2'(t); s.el = 4'(e);
      s.wv = 16'($urandom_range(0, 8191) - 4096);
      send_cmd(s);
    end

    add_row(fpmc_pkg::OpWrite, 10'd1023, '0, '0, '0, fpmc_pkg::TabUser, 4'd15, 16'sd32767,
            1'b1, '0, '0);
    add_row(fpmc_pkg::OpRead, 10'd1023, '0, '0, '0, fpmc_pkg::TabUser, 4'd15, '0,
            1'b1, '0, 16'sd32767);
    add_row(fpmc_pkg::OpWrite, '0, '0, 12'd4095, '0, fpmc_pkg::TabItem, 4'd0, -16'sd32768,
            1'b1, '0, '0);
    add_row(fpmc_pkg::OpRead, '0, '0, 12'd4095, '0, fpmc_pkg::TabItem, 4'd0, '0,
            1'b1, '0, -16'sd32768);
    add_row(fpmc_pkg::OpWrite, '0, '0, 12'd0, '0, fpmc_pkg::TabPrev, 4'd15, 16'sd1,
            1'b1, '0, '0);
    add_row(fpmc_pkg::OpRead, '0, '0, 12'd0, '0, fpmc_pkg::TabPrev, 4'd15, '0,
            1'b1, '0, 16'sd1);
    add_row(fpmc_pkg::OpWrite, '0, '0, 12'hAAA, '0, fpmc_pkg::TabNext, 4'd7, -16'sd1,
            1'b1, '0, '0);
    add_row(fpmc_pkg::OpRead, '0, '0, 12'hAAA, '0, fpmc_pkg::TabNext, 4'd7, '0,
            1'b1, '0, -16'sd1);
    add_row(fpmc_pkg::OpScore, 10'd0, 12'd0, 12'd0, '0, '0, '0, '0, 1'b0, '0, '0);
    add_row(fpmc_pkg::OpScore, 10'd1023, 12'd4095, 12'd4095, '0, '0, '0, '0, 1'b0, '0, '0);
    add_row(fpmc_pkg::OpTrain, 10'h155, 12'h555, 12'hAAA, 12'd7, '0, '0, '0, 1'b0, '0, '0);
    // Positive and negative item the same: the negative write wins.
    add_row(fpmc_pkg::OpTrain, 10'h2AA, 12'd7, 12'd100, 12'd100, '0, '0, '0, 1'b0, '0, '0);
    add_row(fpmc_pkg::OpRead, 10'd1023, '0, 12'd100, '0, fpmc_pkg::TabItem, 4'd3, '0,
            1'b0, '0, '0);
    add_row(fpmc_pkg::OpTrain, 10'd1023, 12'd4095, 12'd4095, 12'd0, '0, '0, '0,
            1'b0, '0, '0);
    add_row(fpmc_pkg::OpScore, 10'h2AA, 12'hAAA, 12'h555, '0, '0, '0, '0, 1'b0, '0, '0);
    add_row(fpmc_pkg::OpRead, '0, '0, 12'd100, '0, fpmc_pkg::TabNext, 4'd12, '0,
            1'b0, '0, '0);
    foreach (dir_tab[k]) send_cmd(dir_tab[k]);

    lr_set  = '{16'd0, 16'd65535, 16'd655, 16'($urandom), 16'd20000};
    lam_set = '{16'd0, 16'd65535, 16'd66, 16'($urandom), 16'd300};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(fpmc_pkg::CfgLearnRate, lr_set[ph]);
      write_reg(fpmc_pkg::CfgRegular, lam_set[ph]);
      repeat (280) send_cmd(random_cmd());
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[fpmc_bpr_sgd_engine] OK");
    else $display("[fpmc_bpr_sgd_engine] ERROR");
    $finish;
  end

  // Result side: random stall pattern with one long hold-off.
  initial begin
    int mode, len;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(5, 80);
      repeat (len) begin
        @(posedge clk);
        if (!held && words_in >= 900) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (LongHold) @(posedge clk);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result check.
  always @(posedge clk) begin
    result_t got, want;
    if (m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word score=%0d read=%0d",
                                   got.score, got.rd);
      end else begin
        want = expected_q.pop_front();
        if (got.score !== want.score || got.rd !== want.rd) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: score exp %0d got %0d, read exp %0d got %0d",
                     want.score, got.score, want.rd, got.rd);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[fpmc_bpr_sgd_engine] ERROR");
      $finish;
    end
  end

endmodule
